FILE: sv/jms_pkg.sv
package jms_pkg;

  localparam int COUNT_BITS_DEF = 32;

  localparam logic [7:0] MK_PREFIX = 8'hFF;
  localparam logic [7:0] MK_SOI    = 8'hD8;
  localparam logic [7:0] MK_APP0   = 8'hE0;
  localparam logic [7:0] MK_APP1   = 8'hE1;
  localparam logic [7:0] MK_DQT    = 8'hDB;
  localparam logic [7:0] MK_EOI    = 8'hD9;
  localparam logic [7:0] MK_RST0   = 8'hD0;
  localparam logic [7:0] MK_RST7   = 8'hD7;
  localparam logic [7:0] MK_SOF0   = 8'hC0;
  localparam logic [7:0] MK_SOF3   = 8'hC3;
  localparam logic [7:0] MK_STUFF  = 8'h00;

  localparam logic [15:0] LEN_MIN     = 16'd2;
  localparam logic [15:0] SOF_LEN_MIN = 16'd7;

  typedef enum logic [8:0] {
    PH_HDR0   = 9'b000000001,
    PH_HDR1   = 9'b000000010,
    PH_SCAN   = 9'b000000100,
    PH_MARK   = 9'b000001000,
    PH_LENHI  = 9'b000010000,
    PH_LENLO  = 9'b000100000,
    PH_SEG    = 9'b001000000,
    PH_BROKEN = 9'b010000000,
    PH_AFTER  = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [31:0] image_length;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        found_end;
    logic        found_size;
    logic        header_ok;
  } result_t;

endpackage

FILE: sv/jpeg_marker_scanner.sv
// JPEG marker scanner: takes one image byte stream, one byte per beat, with last on the
// final byte, checks the FF D8 FF (E0|E1|DB) signature, walks the marker segments
// (skipping fill bytes, FF 00 stuffing and restart markers) and picks height and width
// from the first SOF0..SOF3 segment. One result beat per stream, at EOI or at the last
// byte. Throughput is one byte per cycle: the scan state updates in the cycle a byte is
// taken and results go to a two-entry output buffer, so in_ready drops only when both
// entries hold results the consumer has not taken. Each result is registered in the output
// buffer. The byte counter is COUNT_BITS wide and image_length saturates at 2^32-1.
module jpeg_marker_scanner #(
  parameter int COUNT_BITS = jms_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] image_length,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic        found_end,
  output logic        found_size,
  output logic        header_ok
);

  localparam int WIDE = (COUNT_BITS > 32) ? COUNT_BITS : 33;

  jms_pkg::phase_t        phase, phase_next;
  logic [COUNT_BITS-1:0]  byte_count, byte_count_next;
  logic [15:0]            skip_remaining, skip_remaining_next;
  logic [7:0]             seg_len_high, seg_len_high_next;
  logic                   seg_is_sof, seg_is_sof_next;
  logic [2:0]             sof_byte_index, sof_byte_index_next;
  logic [15:0]            width_reg, width_reg_next;
  logic [15:0]            height_reg, height_reg_next;
  logic                   sof_seen, sof_seen_next;
  logic                   header_good, header_good_next;

  logic                   accept;
  logic                   eoi;
  logic                   emit;
  logic [15:0]            seg_len;
  logic [WIDE-1:0]        count_wide;
  jms_pkg::result_t       res;
  jms_pkg::result_t       out_res;

  assign accept  = in_valid & in_ready;
  assign seg_len = {seg_len_high, data_byte};

  always_comb begin
    phase_next          = phase;
    byte_count_next     = byte_count;
    skip_remaining_next = skip_remaining;
    seg_len_high_next   = seg_len_high;
    seg_is_sof_next     = seg_is_sof;
    sof_byte_index_next = sof_byte_index;
    width_reg_next      = width_reg;
    height_reg_next     = height_reg;
    sof_seen_next       = sof_seen;
    header_good_next    = header_good;
    eoi                 = 1'b0;

    if (byte_count != '1) begin
      byte_count_next = byte_count + COUNT_BITS'(1);
    end

    if (byte_count == COUNT_BITS'(0)) begin
      header_good_next = (data_byte == jms_pkg::MK_PREFIX);
    end else if (byte_count == COUNT_BITS'(1)) begin
      header_good_next = header_good & (data_byte == jms_pkg::MK_SOI);
    end else if (byte_count == COUNT_BITS'(2)) begin
      header_good_next = header_good & (data_byte == jms_pkg::MK_PREFIX);
    end else if (byte_count == COUNT_BITS'(3)) begin
      header_good_next = header_good & ((data_byte == jms_pkg::MK_APP0) ||
                                        (data_byte == jms_pkg::MK_APP1) ||
                                        (data_byte == jms_pkg::MK_DQT));
    end

    case (phase)
      jms_pkg::PH_HDR0: begin
        phase_next = jms_pkg::PH_HDR1;
      end
      jms_pkg::PH_HDR1: begin
        phase_next = jms_pkg::PH_SCAN;
      end
      jms_pkg::PH_SCAN: begin
        if (data_byte == jms_pkg::MK_PREFIX) begin
          phase_next = jms_pkg::PH_MARK;
        end
      end
      jms_pkg::PH_MARK: begin
        if (data_byte == jms_pkg::MK_EOI) begin
          eoi = 1'b1;
        end else if (data_byte == jms_pkg::MK_PREFIX) begin
          phase_next = jms_pkg::PH_MARK;
        end else if (data_byte == jms_pkg::MK_STUFF ||
                     (data_byte >= jms_pkg::MK_RST0 && data_byte <= jms_pkg::MK_RST7)) begin
          phase_next = jms_pkg::PH_SCAN;
        end else begin
          seg_is_sof_next = ~sof_seen & (data_byte >= jms_pkg::MK_SOF0) &
                            (data_byte <= jms_pkg::MK_SOF3);
          phase_next      = jms_pkg::PH_LENHI;
        end
      end
      jms_pkg::PH_LENHI: begin
        seg_len_high_next = data_byte;
        phase_next        = jms_pkg::PH_LENLO;
      end
      jms_pkg::PH_LENLO: begin
        if (seg_len < jms_pkg::LEN_MIN || (seg_is_sof && seg_len < jms_pkg::SOF_LEN_MIN)) begin
          seg_is_sof_next = 1'b0;
          phase_next      = jms_pkg::PH_BROKEN;
        end else begin
          skip_remaining_next = seg_len - jms_pkg::LEN_MIN;
          sof_byte_index_next = 3'd0;
          phase_next = (seg_len == jms_pkg::LEN_MIN) ? jms_pkg::PH_SCAN : jms_pkg::PH_SEG;
        end
      end
      jms_pkg::PH_SEG: begin
        if (seg_is_sof && sof_byte_index < 3'd5) begin
          case (sof_byte_index)
            3'd1:    height_reg_next = {data_byte, height_reg[7:0]};
            3'd2:    height_reg_next = {height_reg[15:8], data_byte};
            3'd3:    width_reg_next  = {data_byte, width_reg[7:0]};
            3'd4:    width_reg_next  = {width_reg[15:8], data_byte};
            default: ;
          endcase
          sof_byte_index_next = sof_byte_index + 3'd1;
        end
        skip_remaining_next = skip_remaining - 16'd1;
        if (skip_remaining == 16'd1) begin
          sof_seen_next   = sof_seen | seg_is_sof;
          seg_is_sof_next = 1'b0;
          phase_next      = jms_pkg::PH_SCAN;
        end
      end
      default: ;
    endcase

    if (eoi) begin
      phase_next = jms_pkg::PH_AFTER;
    end
  end

  assign emit = accept & (eoi | (last & (phase != jms_pkg::PH_AFTER)));

  // result fields come from the post-update state
  assign count_wide = WIDE'(byte_count_next);
  always_comb begin
    res.image_length = (count_wide > WIDE'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : count_wide[31:0];
    res.image_width  = sof_seen_next ? width_reg_next : 16'd0;
    res.image_height = sof_seen_next ? height_reg_next : 16'd0;
    res.found_end    = eoi;
    res.found_size   = sof_seen_next;
    res.header_ok    = header_good_next & (byte_count_next >= COUNT_BITS'(4));
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && last)) begin
      phase          <= jms_pkg::PH_HDR0;
      byte_count     <= '0;
      skip_remaining <= '0;
      seg_len_high   <= '0;
      seg_is_sof     <= 1'b0;
      sof_byte_index <= '0;
      width_reg      <= '0;
      height_reg     <= '0;
      sof_seen       <= 1'b0;
      header_good    <= 1'b0;
    end else if (accept) begin
      phase          <= phase_next;
      byte_count     <= byte_count_next;
      skip_remaining <= skip_remaining_next;
      seg_len_high   <= seg_len_high_next;
      seg_is_sof     <= seg_is_sof_next;
      sof_byte_index <= sof_byte_index_next;
      width_reg      <= width_reg_next;
      height_reg     <= height_reg_next;
      sof_seen       <= sof_seen_next;
      header_good    <= header_good_next;
    end
  end

  jms_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (emit),
    .push_res  (res),
    .buf_ready (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign image_length = out_res.image_length;
  assign image_width  = out_res.image_width;
  assign image_height = out_res.image_height;
  assign found_end    = out_res.found_end;
  assign found_size   = out_res.found_size;
  assign header_ok    = out_res.header_ok;

endmodule

FILE: sv/jms_out_buf.sv
module jms_out_buf (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  jms_pkg::result_t push_res,
  output logic             buf_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output jms_pkg::result_t out_res
);

  jms_pkg::result_t main_res;
  jms_pkg::result_t skid_res;
  logic             main_valid;
  logic             skid_valid;
  logic             pop;

  assign pop       = main_valid & out_ready;
  assign buf_ready = ~skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  // skid entry only fills while the main entry is stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        main_res   <= skid_res;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!main_valid || pop) begin
        main_res   <= push_res;
        main_valid <= 1'b1;
      end else begin
        skid_res   <= push_res;
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      main_valid <= 1'b0;
    end
  end

endmodule

FILE: sv/jms_checker.sv
module jms_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] image_length,
  input logic [15:0] image_width,
  input logic [15:0] image_height,
  input logic        found_end,
  input logic        found_size,
  input logic        header_ok
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(image_length) &&
      $stable(image_width) && $stable(image_height) && $stable(found_end) &&
      $stable(found_size) && $stable(header_ok))
    else $error("result beat changed while stalled");

  a_no_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found_size |-> image_width == 16'd0 && image_height == 16'd0)
    else $error("dimensions without sof");

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> image_length != 32'd0)
    else $error("empty result length");

  a_hdr_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && header_ok |-> image_length >= 32'd4)
    else $error("header ok on short stream");

  // input stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && $past(out_valid) && !$past(out_ready))
    else $error("input stalled without backed-up output");

endmodule

bind jpeg_marker_scanner jms_checker u_jms_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .image_length (image_length),
  .image_width  (image_width),
  .image_height (image_height),
  .found_end    (found_end),
  .found_size   (found_size),
  .header_ok    (header_ok)
);

FILE: tb/tb_jpeg_marker_scanner.sv
module tb_jpeg_marker_scanner;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int                STALL_LIMIT  = 500;
  localparam int                RANDOM_BYTES = 860;
  localparam int                MIN_STREAMS  = 20;
  localparam int                SOF_DIM_END  = 5;
  localparam logic [7:0]        MK_DHT       = 8'hC4;
  localparam jms_pkg::result_t  NO_RESULT    = '0;

  typedef struct packed {
    logic [7:0]       data;
    logic             lst;
    logic             typed;
    jms_pkg::result_t want;
  } plan_row_t;

  localparam int DIR_ROWS = 41;

  plan_row_t dir_table [DIR_ROWS] = '{
    // short stream ending in a lone prefix
    {jms_pkg::MK_PREFIX, 1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_SOI,    1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_PREFIX, 1'b1, 1'b1, 32'd3, 16'd0, 16'd0, 3'b000},
    // good header, segment length zero
    {jms_pkg::MK_PREFIX, 1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_SOI,    1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_PREFIX, 1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_APP0,   1'b0, 1'b0, NO_RESULT},
    {8'h00,              1'b0, 1'b0, NO_RESULT},
    {8'h00,              1'b1, 1'b1, 32'd6, 16'd0, 16'd0, 3'b001},
    // first sof segment too short
    {jms_pkg::MK_PREFIX,       1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_SOI,          1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_PREFIX,       1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_SOF0 + 8'd1,  1'b0, 1'b0, NO_RESULT},
    {8'h00,                    1'b0, 1'b0, NO_RESULT},
    {8'h06,                    1'b1, 1'b1, 32'd6, 16'd0, 16'd0, 3'b000},
    // sof segment cut off by the end of stream
    {jms_pkg::MK_PREFIX, 1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_SOI,    1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_PREFIX, 1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_SOF0,   1'b0, 1'b0, NO_RESULT},
    {8'h00,              1'b0, 1'b0, NO_RESULT},
    {8'h07,              1'b0, 1'b0, NO_RESULT},
    {8'h08,              1'b1, 1'b1, 32'd7, 16'd0, 16'd0, 3'b000},
    // sof, stuffing, fill, restart, eoi, then a trailing byte
    {jms_pkg::MK_PREFIX, 1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_SOI,    1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_PREFIX, 1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_SOF0,   1'b0, 1'b0, NO_RESULT},
    {8'h00,              1'b0, 1'b0, NO_RESULT},
    {8'h07,              1'b0, 1'b0, NO_RESULT},
    {8'h08,              1'b0, 1'b0, NO_RESULT},
    {8'h12,              1'b0, 1'b0, NO_RESULT},
    {8'h34,              1'b0, 1'b0, NO_RESULT},
    {8'hAB,              1'b0, 1'b0, NO_RESULT},
    {8'hCD,              1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_PREFIX, 1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_STUFF,  1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_PREFIX, 1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_PREFIX, 1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_RST7,   1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_PREFIX, 1'b0, 1'b0, NO_RESULT},
    {jms_pkg::MK_EOI,    1'b0, 1'b0, NO_RESULT},
    {8'h55,              1'b1, 1'b0, NO_RESULT}
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        last      = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] image_length;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic        found_end;
  logic        found_size;
  logic        header_ok;

  logic             cur_typed = 1'b0;
  jms_pkg::result_t cur_want  = '0;
  logic             calm_tail = 1'b0;

  plan_row_t        byte_plan [$];
  logic [7:0]       stream_buf [$];
  jms_pkg::result_t pending_results [$];
  int               mismatches   = 0;
  int               quiet_cycles = 0;

  jms_pkg::phase_t sc_phase;
  logic [31:0]     sc_count;
  logic [15:0]     sc_skip;
  logic [7:0]      sc_len_hi;
  logic            sc_in_sof;
  logic [2:0]      sc_sof_idx;
  logic [15:0]     sc_width;
  logic [15:0]     sc_height;
  logic            sc_sof_done;
  logic            sc_hdr_good;

  jpeg_marker_scanner dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .last         (last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .image_length (image_length),
    .image_width  (image_width),
    .image_height (image_height),
    .found_end    (found_end),
    .found_size   (found_size),
    .header_ok    (header_ok)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic scan_clear();
    sc_phase    = jms_pkg::PH_HDR0;
    sc_count    = '0;
    sc_skip     = '0;
    sc_len_hi   = '0;
    sc_in_sof   = 1'b0;
    sc_sof_idx  = '0;
    sc_width    = '0;
    sc_height   = '0;
    sc_sof_done = 1'b0;
    sc_hdr_good = 1'b0;
  endtask

  task automatic scan_predict(input logic [7:0] b, input logic lst,
                              output logic got, output jms_pkg::result_t r);
    logic [31:0] pos;
    logic        eoi;
    logic [15:0] seg_len;
    pos = sc_count;
    eoi = 1'b0;
    if (sc_count != 32'hFFFF_FFFF) sc_count = sc_count + 32'd1;

    if (pos == 0) sc_hdr_good = (b == jms_pkg::MK_PREFIX);
    else if (pos == 1) sc_hdr_good = sc_hdr_good && (b == jms_pkg::MK_SOI);
    else if (pos == 2) sc_hdr_good = sc_hdr_good && (b == jms_pkg::MK_PREFIX);
    else if (pos == 3) sc_hdr_good = sc_hdr_good &&
        (b == jms_pkg::MK_APP0 || b == jms_pkg::MK_APP1 || b == jms_pkg::MK_DQT);

    case (sc_phase)
      jms_pkg::PH_HDR0: sc_phase = jms_pkg::PH_HDR1;
      jms_pkg::PH_HDR1: sc_phase = jms_pkg::PH_SCAN;
      jms_pkg::PH_SCAN: begin
        if (b == jms_pkg::MK_PREFIX) sc_phase = jms_pkg::PH_MARK;
      end
      jms_pkg::PH_MARK: begin
        if (b == jms_pkg::MK_EOI) begin
          eoi = 1'b1;
        end else if (b == jms_pkg::MK_PREFIX) begin
          // fill byte, stay on the marker
        end else if (b == jms_pkg::MK_STUFF ||
                     (b >= jms_pkg::MK_RST0 && b <= jms_pkg::MK_RST7)) begin
          sc_phase = jms_pkg::PH_SCAN;
        end else begin
          sc_in_sof = !sc_sof_done && b >= jms_pkg::MK_SOF0 && b <= jms_pkg::MK_SOF3;
          sc_phase  = jms_pkg::PH_LENHI;
        end
      end
      jms_pkg::PH_LENHI: begin
        sc_len_hi = b;
        sc_phase  = jms_pkg::PH_LENLO;
      end
      jms_pkg::PH_LENLO: begin
        seg_len = {sc_len_hi, b};
        if (seg_len < jms_pkg::LEN_MIN || (sc_in_sof && seg_len < jms_pkg::SOF_LEN_MIN)) begin
          sc_in_sof = 1'b0;
          sc_phase  = jms_pkg::PH_BROKEN;
        end else begin
          sc_skip    = seg_len - jms_pkg::LEN_MIN;
          sc_sof_idx = '0;
          sc_phase   = (sc_skip == 0) ? jms_pkg::PH_SCAN : jms_pkg::PH_SEG;
        end
      end
      jms_pkg::PH_SEG: begin
        if (sc_in_sof && sc_sof_idx < SOF_DIM_END) begin
          case (sc_sof_idx)
            3'd1: sc_height[15:8] = b;
            3'd2: sc_height[7:0]  = b;
            3'd3: sc_width[15:8]  = b;
            3'd4: sc_width[7:0]   = b;
            default: ;
          endcase
          sc_sof_idx = sc_sof_idx + 3'd1;
        end
        sc_skip = sc_skip - 16'd1;
        if (sc_skip == 0) begin
          if (sc_in_sof) sc_sof_done = 1'b1;
          sc_in_sof = 1'b0;
          sc_phase  = jms_pkg::PH_SCAN;
        end
      end
      default: ;
    endcase

    got = eoi || (lst && sc_phase != jms_pkg::PH_AFTER);
    r.image_length = sc_count;
    r.image_width  = sc_sof_done ? sc_width : 16'd0;
    r.image_height = sc_sof_done ? sc_height : 16'd0;
    r.found_end    = eoi;
    r.found_size   = sc_sof_done;
    r.header_ok    = sc_hdr_good && (sc_count >= 4);
    if (eoi) sc_phase = jms_pkg::PH_AFTER;
    if (lst) scan_clear();
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      mismatches++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
    end
  endtask

  task automatic add_segment(input logic [7:0] mk, input logic [15:0] seg_len,
                             input int body_n);
    stream_buf.push_back(jms_pkg::MK_PREFIX);
    stream_buf.push_back(mk);
    stream_buf.push_back(seg_len[15:8]);
    stream_buf.push_back(seg_len[7:0]);
    repeat (body_n) stream_buf.push_back(8'($urandom_range(0, 255)));
  endtask

  task automatic add_stream();
    int         kind;
    int         body_n;
    int         cut;
    logic [7:0] mk;
    logic [7:0] v;
    plan_row_t  row;
    stream_buf.delete();
    kind = $urandom_range(0, 99);
    if (kind >= 93) begin
      // noise, often shorter than the header
      repeat ($urandom_range(1, 12)) stream_buf.push_back(8'($urandom_range(0, 255)));
    end else begin
      stream_buf.push_back(jms_pkg::MK_PREFIX);
      stream_buf.push_back(jms_pkg::MK_SOI);
      case ($urandom_range(0, 2))
        0:       mk = jms_pkg::MK_APP0;
        1:       mk = jms_pkg::MK_APP1;
        default: mk = jms_pkg::MK_DQT;
      endcase
      body_n = $urandom_range(0, 6);
      add_segment(mk, 16'(body_n + 2), body_n);
      if ($urandom_range(0, 7) == 0)
        stream_buf[$urandom_range(0, 3)] ^= 8'(1 << $urandom_range(0, 7));

      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 3) == 0)
          repeat ($urandom_range(1, 2)) stream_buf.push_back(jms_pkg::MK_PREFIX);
        if ($urandom_range(0, 2) == 0) begin
          mk     = jms_pkg::MK_SOF0 + 8'($urandom_range(0, 3));
          body_n = $urandom_range(5, 10);
        end else begin
          mk = 8'($urandom_range(1, 254));
          if (mk >= jms_pkg::MK_RST0 && mk <= jms_pkg::MK_EOI) mk = MK_DHT;
          body_n = ($urandom_range(0, 149) == 0) ? $urandom_range(254, 300)
                                                 : $urandom_range(0, 6);
        end
        add_segment(mk, 16'(body_n + 2), body_n);
      end

      if (kind >= 70 && kind < 85) begin
        if ($urandom_range(0, 1) == 1)
          add_segment(jms_pkg::MK_SOF0 + 8'($urandom_range(0, 3)),
                      16'($urandom_range(0, 6)), $urandom_range(0, 4));
        else
          add_segment(MK_DHT, 16'($urandom_range(0, 1)), $urandom_range(0, 4));
      end

      repeat ($urandom_range(0, 8)) begin
        case ($urandom_range(0, 7))
          0: begin
            stream_buf.push_back(jms_pkg::MK_PREFIX);
            stream_buf.push_back(jms_pkg::MK_STUFF);
          end
          1: begin
            stream_buf.push_back(jms_pkg::MK_PREFIX);
            stream_buf.push_back(jms_pkg::MK_RST0 + 8'($urandom_range(0, 7)));
          end
          2: begin
            stream_buf.push_back(jms_pkg::MK_PREFIX);
            stream_buf.push_back(jms_pkg::MK_PREFIX);
            stream_buf.push_back(jms_pkg::MK_RST0 + 8'($urandom_range(0, 7)));
          end
          default: begin
            v = 8'($urandom_range(0, 255));
            stream_buf.push_back(v);
            if (v == jms_pkg::MK_PREFIX) stream_buf.push_back(jms_pkg::MK_STUFF);
          end
        endcase
      end

      if ($urandom_range(0, 9) != 0) begin
        stream_buf.push_back(jms_pkg::MK_PREFIX);
        stream_buf.push_back(jms_pkg::MK_EOI);
      end
      repeat ($urandom_range(0, 3)) stream_buf.push_back(8'($urandom_range(0, 255)));

      if (kind >= 85) begin
        cut = $urandom_range(1, stream_buf.size());
        while (stream_buf.size() > cut) void'(stream_buf.pop_back());
      end
    end

    foreach (stream_buf[k]) begin
      row.data  = stream_buf[k];
      row.lst   = (k == stream_buf.size() - 1);
      row.typed = 1'b0;
      row.want  = NO_RESULT;
      byte_plan.push_back(row);
    end
  endtask

  always @(posedge clk) begin : scoreboard
    logic             got;
    jms_pkg::result_t guess;
    jms_pkg::result_t seen;
    if (rst) begin
      scan_clear();
      pending_results.delete();
    end else begin
      if (in_valid && in_ready) begin
        scan_predict(data_byte, last, got, guess);
        if (cur_typed) pending_results.push_back(cur_want);
        else if (got) pending_results.push_back(guess);
      end
      if (out_valid && out_ready) begin
        seen = {image_length, image_width, image_height, found_end, found_size, header_ok};
        if (pending_results.size() == 0) begin
          mismatches++;
          $display("%0t: result beat expected none actual length %0h",
                   $time, image_length);
        end else begin
          guess = pending_results.pop_front();
          check_field("image_length", guess.image_length, seen.image_length);
          check_field("image_width", 32'(guess.image_width), 32'(seen.image_width));
          check_field("image_height", 32'(guess.image_height), 32'(seen.image_height));
          check_field("found_end", 32'(guess.found_end), 32'(seen.found_end));
          check_field("found_size", 32'(guess.found_size), 32'(seen.found_size));
          check_field("header_ok", 32'(guess.header_ok), 32'(seen.header_ok));
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("jpeg_marker_scanner regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int   stall_left;
    logic stalls_on;
    stall_left = 0;
    stalls_on  = 1'b1;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 199) == 0) stalls_on = !stalls_on;
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else if (!calm_tail && stalls_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        stall_left = $urandom_range(1, 14) - 1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : byte_source
    int unsigned i;
    int          streams;
    logic        gaps_on;
    foreach (dir_table[r]) byte_plan.push_back(dir_table[r]);
    streams = 0;
    while (byte_plan.size() < DIR_ROWS + RANDOM_BYTES || streams < MIN_STREAMS) begin
      add_stream();
      streams++;
    end

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    gaps_on = 1'b1;

    for (i = 0; i < byte_plan.size(); i++) begin
      calm_tail = (i + 100 >= byte_plan.size());
      if ($urandom_range(0, 49) == 0) gaps_on = !gaps_on;
      if (!calm_tail && gaps_on && $urandom_range(0, 5) == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      in_valid  <= 1'b1;
      data_byte <= byte_plan[i].data;
      last      <= byte_plan[i].lst;
      cur_typed <= byte_plan[i].typed;
      cur_want  <= byte_plan[i].want;
      // hold the beat until it is taken
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("jpeg_marker_scanner regression: pass");
    end else begin
      $display("jpeg_marker_scanner regression: fail");
    end
    $finish;
  end

endmodule
